[sv/hsc_pkg.sv]
// shared types, constants and tables for the hamming secded check codec
`default_nettype none

package hsc_pkg;

  localparam int unsigned DataW       = 64;
  localparam int unsigned CheckW      = 8;
  localparam int unsigned NumBytes    = DataW / 8;
  localparam int unsigned PosW        = 7;
  localparam int unsigned BytesW      = 4;
  localparam int unsigned MaxBytesDef = 8;
  localparam logic [BytesW-1:0] DataBytesRst = 4'd8;

  localparam logic OpEncode = 1'b0;
  localparam logic OpDecode = 1'b1;

  typedef logic [PosW-1:0] pos_t;
  typedef pos_t pos_tab_t [DataW];

  typedef struct packed {
    logic single_corrected;
    logic double_detected;
  } hsc_flags_t;

  // codeword position of each data bit: the non-power-of-two positions in order
  function automatic pos_tab_t build_pos();
    pos_tab_t    tab;
    int unsigned cnt;
    int unsigned pos;
    cnt = 0;
    for (int unsigned i = 0; i < DataW; i++) begin
      tab[i] = '0;
    end
    for (pos = 3; pos < (1 << PosW); pos++) begin
      if ((pos & (pos - 1)) != 0) begin
        if (cnt < DataW) begin
          tab[cnt] = pos_t'(pos);
        end
        cnt++;
      end
    end
    return tab;
  endfunction

  localparam pos_tab_t DataPos = build_pos();

  // check bit count for a byte count of 1..8
  function automatic logic [2:0] check_bit_count(input logic [BytesW-1:0] nb);
    logic [2:0] p;
    if (nb == 4'd1) begin
      p = 3'd4;
    end else if (nb <= 4'd3) begin
      p = 3'd5;
    end else if (nb <= 4'd7) begin
      p = 3'd6;
    end else begin
      p = 3'd7;
    end
    return p;
  endfunction

endpackage

`default_nettype wire

[sv/hamming_secded_check_codec_unit.sv]
// top level of the hamming secded check codec: stream ports, pipeline registers, config
`default_nettype none

// Extended Hamming (SECDED) encoder and checker over a data word of 1 to 8 bytes.
// Opcode 0 returns the check byte for the word; opcode 1 checks the word against the
// received check byte, corrects a single data bit error and flags single or double
// errors. The block is a two-register pipeline (input register, result register)
// with the whole codec in one combinational pass between them: one word is taken
// every cycle and its result passes through the result register to the output,
// as long as the output side keeps taking results. data_bytes may only be written
// while no word is in flight; values 0 and above MAX_DATA_BYTES are clamped into range.

module hamming_secded_check_codec_unit
  import hsc_pkg::*;
#(
  parameter int unsigned MAX_DATA_BYTES = MaxBytesDef
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      cfg_we_i,
  input  wire logic [BytesW-1:0]         cfg_wdata_i,
  input  wire logic                      s_axis_tvalid,
  output      logic                      s_axis_tready,
  // [63:0] data_word, [71:64] check_in
  input  wire logic [DataW+CheckW-1:0]   s_axis_tdata,
  // [0] opcode
  input  wire logic                      s_axis_tuser,
  output      logic                      m_axis_tvalid,
  input  wire logic                      m_axis_tready,
  // [63:0] data_out, [71:64] check_out
  output      logic [DataW+CheckW-1:0]   m_axis_tdata,
  // [0] single_corrected, [1] double_detected
  output      logic [1:0]                m_axis_tuser
);

  logic [BytesW-1:0]  data_bytes_q;
  logic [BytesW-1:0]  nbytes_eff;

  logic               in_vld_q;
  logic               in_op_q;
  logic [DataW-1:0]   in_data_q;
  logic [CheckW-1:0]  in_chk_q;

  logic               out_vld_q;
  logic [DataW-1:0]   out_data_q;
  logic [CheckW-1:0]  out_chk_q;
  hsc_flags_t         out_flags_q;

  logic [DataW-1:0]   core_data;
  logic [CheckW-1:0]  core_chk;
  hsc_flags_t         core_flags;

  logic               adv_out;
  logic               take_in;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      data_bytes_q <= DataBytesRst;
    end else if (cfg_we_i) begin
      data_bytes_q <= cfg_wdata_i;
    end
  end

  always_comb begin
    if (data_bytes_q == '0) begin
      nbytes_eff = BytesW'(1);
    end else if (data_bytes_q > BytesW'(MAX_DATA_BYTES)) begin
      nbytes_eff = BytesW'(MAX_DATA_BYTES);
    end else begin
      nbytes_eff = data_bytes_q;
    end
  end

  assign adv_out       = !out_vld_q || m_axis_tready;
  assign s_axis_tready = !in_vld_q || adv_out;
  assign take_in       = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_vld_q <= s_axis_tvalid;
      end
      if (adv_out) begin
        out_vld_q <= in_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_in) begin
      in_op_q   <= s_axis_tuser;
      in_data_q <= s_axis_tdata[DataW-1:0];
      in_chk_q  <= s_axis_tdata[DataW +: CheckW];
    end
    if (adv_out && in_vld_q) begin
      out_data_q  <= core_data;
      out_chk_q   <= core_chk;
      out_flags_q <= core_flags;
    end
  end

  hsc_core u_core (
    .opcode_i (in_op_q),
    .data_i   (in_data_q),
    .check_i  (in_chk_q),
    .nbytes_i (nbytes_eff),
    .data_o   (core_data),
    .check_o  (core_chk),
    .flags_o  (core_flags)
  );

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {out_chk_q, out_data_q};
  assign m_axis_tuser  = {out_flags_q.double_detected, out_flags_q.single_corrected};

endmodule

`default_nettype wire

[sv/hsc_core.sv]
// check byte generation, syndrome decode and single bit correction
`default_nettype none

module hsc_core
  import hsc_pkg::*;
(
  input  wire logic                opcode_i,
  input  wire logic [DataW-1:0]    data_i,
  input  wire logic [CheckW-1:0]   check_i,
  input  wire logic [BytesW-1:0]   nbytes_i,
  output      logic [DataW-1:0]    data_o,
  output      logic [CheckW-1:0]   check_o,
  output      hsc_flags_t          flags_o
);

  logic [DataW-1:0]  byte_mask;
  logic [DataW-1:0]  data_m;
  logic [DataW-1:0]  flip;
  logic [2:0]        p;
  pos_t              pmask;
  pos_t              n_plus_p;
  pos_t              chk_full;
  pos_t              chk;
  pos_t              syn;
  logic              ovr;
  logic              fail;
  logic              is_single;
  logic              is_double;
  logic              fix_data;

  always_comb begin
    for (int unsigned b = 0; b < NumBytes; b++) begin
      byte_mask[b*8 +: 8] = ({1'b0, nbytes_i} > 5'(b)) ? 8'hff : 8'h00;
    end
  end

  assign data_m   = data_i & byte_mask;
  assign p        = check_bit_count(nbytes_i);
  assign pmask    = pos_t'((8'd1 << p) - 8'd1);
  assign n_plus_p = pos_t'({nbytes_i, 3'b000}) + pos_t'(p);

  // parity trees, one per position bit
  always_comb begin
    chk_full = '0;
    for (int unsigned k = 0; k < DataW; k++) begin
      chk_full = chk_full ^ (DataPos[k] & {PosW{data_m[k]}});
    end
  end

  assign chk     = chk_full & pmask;
  assign ovr     = (^data_m) ^ (^chk);
  assign check_o = CheckW'(chk) | (CheckW'(ovr) << p);

  assign syn  = (check_i[PosW-1:0] ^ chk) & pmask;
  assign fail = check_i[p] ^ ovr ^ (^syn);

  always_comb begin
    is_single = 1'b0;
    is_double = 1'b0;
    fix_data  = 1'b0;
    if (opcode_i == OpDecode) begin
      if (syn == '0) begin
        is_single = fail;
      end else if (!fail) begin
        is_double = 1'b1;
      end else if (syn > n_plus_p) begin
        // no codeword position at this syndrome
        is_double = 1'b1;
      end else begin
        is_single = 1'b1;
        fix_data  = 1'b1;
      end
    end
  end

  // data positions are never powers of two, so a check bit error flips nothing
  always_comb begin
    for (int unsigned k = 0; k < DataW; k++) begin
      flip[k] = fix_data && (syn == DataPos[k]);
    end
  end

  assign data_o                   = (data_m ^ flip) & byte_mask;
  assign flags_o.single_corrected = is_single;
  assign flags_o.double_detected  = is_double;

endmodule

`default_nettype wire
